@@ hw/rtl/urc_pkg.sv @@
package urc_pkg;

	localparam int CMD_W = 2;
	localparam int DIST_W = 12;
	localparam int COUNT_W = 16;
	localparam int TRIG_MS_W = 8;
	localparam int WIN_MS_W = 16;
	localparam int MAX_ECHO_W = 11;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int IN_DATA_W = 8;
	localparam int OUT_DATA_W = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_MS_TICK = 2'd0,
		CMD_SAMPLE = 2'd1,
		CMD_READ = 2'd2,
		CMD_START = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_TRIGGER_MS = 2'd0,
		REG_WINDOW_MS = 2'd1,
		REG_MAX_ECHO = 2'd2
	} reg_idx_t;

	localparam logic [TRIG_MS_W-1:0] TRIG_MS_RST = 8'd1;
	localparam logic [WIN_MS_W-1:0] WIN_MS_RST = 16'd60;
	localparam logic [MAX_ECHO_W-1:0] MAX_ECHO_RST = 11'd235;

	// x / 10 equals (x * 52429) >> 19 for every 16-bit x.
	localparam logic [15:0] DIV10_MUL = 16'd52429;
	localparam int DIV10_SHIFT = 19;

endpackage

@@ hw/rtl/ultrasonic_range_controller.sv @@
// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   s_tuser command, s_tdata echo level
// m_*       out        m_tvalid/m_tready   m_tdata distance, ready, trigger, phase
// apb       in         psel/penable        trigger_ms, window_ms, max_echo_count
//
// The state updates at the accepting edge and the result word is registered at the same
// edge, so a new word can be accepted in every cycle unless the output register stalls.
// A single output register holds the result; s_tready is low only while it is full
// and m_tready is low. Reset clears the phase, counters and the output valid flag.
module ultrasonic_range_controller
	import urc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // [0] echo_level, rest zero
	input  logic [CMD_W-1:0]      s_tuser,  // [1:0] command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // [11:0] distance_cm, [12] ready_res,
	                                        // [13] trigger_level, [15:14] phase
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TRIGGER = 2'd1,
		PH_WAITING = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	logic [TRIG_MS_W-1:0] trigger_ms_q;
	logic [WIN_MS_W-1:0] window_ms_q;
	logic [MAX_ECHO_W-1:0] max_echo_q;

	phase_t phase_q, phase_d;
	logic [COUNT_W-1:0] ms_count_q, ms_count_d, ms_inc;
	logic [COUNT_W-1:0] echo_count_q, echo_count_d;
	logic [DIST_W-1:0] distance_q, distance_d;
	logic trigger_q, trigger_d;
	logic out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic in_fire;
	logic cfg_wr;
	reg_idx_t cfg_idx;
	cmd_t cmd;
	logic [MAX_ECHO_W-1:0] clamped;
	logic [COUNT_W-1:0] times17;
	logic [2*COUNT_W-1:0] quot_prod;

	assign s_tready = !out_valid_q || m_tready;
	assign in_fire = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign cmd = cmd_t'(s_tuser);

	assign pready = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_TRIGGER_MS: prdata = {{(APB_DATA_W-TRIG_MS_W){1'b0}}, trigger_ms_q};
			REG_WINDOW_MS: prdata = {{(APB_DATA_W-WIN_MS_W){1'b0}}, window_ms_q};
			REG_MAX_ECHO: prdata = {{(APB_DATA_W-MAX_ECHO_W){1'b0}}, max_echo_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_ms_q <= TRIG_MS_RST;
			window_ms_q <= WIN_MS_RST;
			max_echo_q <= MAX_ECHO_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_TRIGGER_MS: trigger_ms_q <= pwdata[TRIG_MS_W-1:0];
				REG_WINDOW_MS: window_ms_q <= pwdata[WIN_MS_W-1:0];
				REG_MAX_ECHO: max_echo_q <= pwdata[MAX_ECHO_W-1:0];
				default: ;
			endcase
		end
	end

	assign ms_inc = (ms_count_q == {COUNT_W{1'b1}}) ? ms_count_q : ms_count_q + COUNT_W'(1);

	// An echo count above the limit reads as zero; otherwise it fits the limit width.
	assign clamped = (echo_count_q > {{(COUNT_W-MAX_ECHO_W){1'b0}}, max_echo_q})
		? '0 : echo_count_q[MAX_ECHO_W-1:0];
	assign times17 = {1'b0, clamped, 4'b0000} + {{(COUNT_W-MAX_ECHO_W){1'b0}}, clamped};
	assign quot_prod = times17 * DIV10_MUL;

	always_comb begin
		phase_d = phase_q;
		ms_count_d = ms_count_q;
		echo_count_d = echo_count_q;
		distance_d = distance_q;
		trigger_d = trigger_q;
		case (cmd)
			CMD_MS_TICK: begin
				if (phase_q == PH_TRIGGER) begin
					ms_count_d = ms_inc;
					if (ms_inc >= {{(COUNT_W-TRIG_MS_W){1'b0}}, trigger_ms_q}) begin
						trigger_d = 1'b0;
						echo_count_d = '0;
						ms_count_d = '0;
						phase_d = PH_WAITING;
					end
				end else if (phase_q == PH_WAITING) begin
					ms_count_d = ms_inc;
					if (ms_inc >= window_ms_q) begin
						echo_count_d = {{(COUNT_W-MAX_ECHO_W){1'b0}}, clamped};
						distance_d = quot_prod[DIV10_SHIFT+DIST_W-1:DIV10_SHIFT];
						phase_d = PH_DONE;
					end
				end
			end
			CMD_SAMPLE: begin
				if (phase_q == PH_WAITING && s_tdata[0] && echo_count_q != {COUNT_W{1'b1}}) begin
					echo_count_d = echo_count_q + COUNT_W'(1);
				end
			end
			CMD_READ: begin
				if (phase_q == PH_IDLE) begin
					trigger_d = 1'b1;
					ms_count_d = '0;
					phase_d = PH_TRIGGER;
				end else if (phase_q == PH_DONE) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				if (phase_q == PH_IDLE) begin
					trigger_d = 1'b1;
					ms_count_d = '0;
					phase_d = PH_TRIGGER;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ms_count_q <= '0;
			echo_count_q <= '0;
			distance_q <= '0;
			trigger_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				phase_q <= phase_d;
				ms_count_q <= ms_count_d;
				echo_count_q <= echo_count_d;
				distance_q <= distance_d;
				trigger_q <= trigger_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_data_q <= {phase_d, trigger_d, (phase_d == PH_DONE), distance_d};
		end
	end

endmodule
